// File: src/rps_pkg.sv
// Shared types, constants and helper functions for the reflow profile sequencer.
// Used by rps_cfg_regs, rps_core and reflow_profile_sequencer_unit.
`default_nettype none

package rps_pkg;

  localparam int NUM_STAGES = 5;
  localparam int STAGE_W    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 25;

  // Register indexes above the stage profiles.
  localparam logic [CFG_INDEX_W-1:0] REG_CONSTANT_MODE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_TILT    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_WATT_LIMIT    = 3'd7;

  // Safety thresholds.
  localparam logic [2:0]         TILT_LIMIT     = 3'd5;
  localparam logic [4:0]         LOW_VOLT_LIMIT = 5'd20;
  localparam logic [14:0]        LOW_VOLT_MV    = 15'd16500;
  localparam logic [12:0]        ACC_ALL_LO     = 13'd800;
  localparam logic [12:0]        ACC_ALL_HI     = 13'd1200;
  localparam logic signed [13:0] ACC_Z_LO       = 14'sd900;
  localparam logic signed [13:0] ACC_Z_HI       = 14'sd1100;
  localparam logic signed [15:0] WINDOW_TENTHS  = 16'sd50;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_TILT     = 2'd1,
    REASON_LOW_VOLT = 2'd2,
    REASON_DONE     = 2'd3
  } reason_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0][8:0]  stage_temp;
    logic [NUM_STAGES-1:0][15:0] stage_dur;
    logic                        constant_mode;
    logic                        check_tilt;
    logic [7:0]                  watt_limit;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [13:0] pad_temp_tenths;
    logic [12:0]        acc_total_mg;
    logic signed [13:0] accel_z_mg;
    logic [14:0]        supply_mv;
    logic [15:0]        elapsed_ms;
  } item_t;

  typedef struct packed {
    logic               running;
    logic [STAGE_W-1:0] stage;
    logic [31:0]        dwell_ms;
    logic [2:0]         tilt_count;
    logic [4:0]         low_volt_count;
  } state_t;

  typedef struct packed {
    logic       heater_on;
    logic [8:0] target_temp;
    logic [7:0] max_power;
    logic [2:0] stage_now;
    reason_t    stop_reason;
  } result_t;

  // Degrees to tenths: t*10 = t*8 + t*2.
  function automatic logic [12:0] deg_to_tenths(input logic [8:0] t);
    return {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
  endfunction

  // Seconds to milliseconds: s*1000 = s*1024 - s*16 - s*8.
  function automatic logic [25:0] sec_to_ms(input logic [15:0] s);
    return {s, 10'b0} - {6'b0, s, 4'b0} - {7'b0, s, 3'b0};
  endfunction

endpackage

`default_nettype wire

// File: src/reflow_profile_sequencer_unit.sv
// Top level of the reflow profile sequencer: input register, core, result register.
// Depends on rps_pkg, rps_cfg_regs and rps_core.
//
//   port group     | direction | handshake          | contents
//   ---------------+-----------+--------------------+------------------------------------
//   input item     | in        | in_valid/in_stall  | cmd, pad temp, acceleration, supply, ms
//   result item    | out       | out_valid/out_stall| heater_on, target, power, stage, reason
//   configuration  | in        | cfg_write          | cfg_index, cfg_data (no read-back)
//
// One transaction per cycle is sustained while out_stall is low; a result is presented
// once its item moves via the single update pass from the item register into the result register.
// Reset clears the sequencer state and loads the register reset values; no clearing
// pass is needed. A stall on the result side holds the result register and, once the
// input register is also full, raises in_stall in the same cycle.
`default_nettype none

module reflow_profile_sequencer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      cmd,
  input  wire logic signed [13:0]              pad_temp_tenths,
  input  wire logic [12:0]                     acc_total_mg,
  input  wire logic signed [13:0]              accel_z_mg,
  input  wire logic [14:0]                     supply_mv,
  input  wire logic [15:0]                     elapsed_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 heater_on,
  output logic [8:0]                           target_temp,
  output logic [7:0]                           max_power,
  output logic [2:0]                           stage_now,
  output logic [1:0]                           stop_reason,
  input  wire logic                            cfg_write,
  input  wire logic [rps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rps_pkg::cfg_t    cfg;
  rps_pkg::item_t   item;
  rps_pkg::result_t core_result;
  rps_pkg::result_t result;
  logic             item_valid;
  logic             advance;

  rps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves into the result register whenever that register is free.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd             <= rps_pkg::cmd_t'(cmd);
      item.pad_temp_tenths <= pad_temp_tenths;
      item.acc_total_mg    <= acc_total_mg;
      item.accel_z_mg      <= accel_z_mg;
      item.supply_mv       <= supply_mv;
      item.elapsed_ms      <= elapsed_ms;
    end
  end

  rps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign heater_on   = result.heater_on;
  assign target_temp = result.target_temp;
  assign max_power   = result.max_power;
  assign stage_now   = result.stage_now;
  assign stop_reason = result.stop_reason;

endmodule

`default_nettype wire

// File: src/rps_cfg_regs.sv
// Configuration register file of the reflow profile sequencer.
// Depends on rps_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module rps_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [rps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rps_pkg::cfg_t                           cfg
);

  rps_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stage_temp    <= '0;
      regs.stage_dur     <= '0;
      regs.constant_mode <= 1'b0;
      regs.check_tilt    <= 1'b1;
      regs.watt_limit    <= '0;
    end else if (cfg_write) begin
      for (int i = 0; i < rps_pkg::NUM_STAGES; i++) begin
        if (cfg_index == rps_pkg::CFG_INDEX_W'(i)) begin
          regs.stage_temp[i] <= cfg_data[24:16];
          regs.stage_dur[i]  <= cfg_data[15:0];
        end
      end
      case (cfg_index)
        rps_pkg::REG_CONSTANT_MODE: regs.constant_mode <= cfg_data[0];
        rps_pkg::REG_CHECK_TILT:    regs.check_tilt    <= cfg_data[0];
        rps_pkg::REG_WATT_LIMIT:    regs.watt_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: src/rps_core.sv
// Sequencer state and the one-pass update for a single transaction.
// Depends on rps_pkg; the enclosing level supplies the registered item.
`default_nettype none

module rps_core (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire rps_pkg::item_t  item,
  input  wire rps_pkg::cfg_t   cfg,
  output rps_pkg::result_t result
);

  rps_pkg::state_t state;
  rps_pkg::state_t state_next;

  always_comb begin
    logic                        stopped;
    logic                        tilt;
    logic [8:0]                  temp_cur;
    logic signed [15:0]          diff;
    logic [32:0]                 sum;
    logic [rps_pkg::STAGE_W:0]   stage_inc;
    logic                        has_next;
    logic [rps_pkg::STAGE_W-1:0] next_idx;
    rps_pkg::reason_t            reason;

    state_next = state;
    reason     = rps_pkg::REASON_NONE;
    stopped    = 1'b0;
    tilt       = (item.acc_total_mg < rps_pkg::ACC_ALL_LO) ||
                 (item.acc_total_mg > rps_pkg::ACC_ALL_HI) ||
                 (item.accel_z_mg < rps_pkg::ACC_Z_LO) ||
                 (item.accel_z_mg > rps_pkg::ACC_Z_HI);
    temp_cur   = cfg.stage_temp[state.stage];
    diff       = 16'(signed'({{2{item.pad_temp_tenths[13]}}, item.pad_temp_tenths}))
               - signed'({3'b000, rps_pkg::deg_to_tenths(temp_cur)});
    sum        = {1'b0, state.dwell_ms} + {17'b0, item.elapsed_ms};
    stage_inc  = {1'b0, state.stage} + 1'b1;
    has_next   = 1'b0;
    next_idx   = state.stage;
    if (stage_inc < (rps_pkg::STAGE_W + 1)'(rps_pkg::NUM_STAGES)) begin
      next_idx = stage_inc[rps_pkg::STAGE_W-1:0];
      has_next = (cfg.stage_dur[next_idx] != 16'd0);
    end

    case (item.cmd)
      rps_pkg::CMD_START: begin
        state_next.running        = 1'b1;
        state_next.stage          = '0;
        state_next.dwell_ms       = '0;
        state_next.tilt_count     = '0;
        state_next.low_volt_count = '0;
      end
      rps_pkg::CMD_STOP: begin
        state_next.running = 1'b0;
      end
      rps_pkg::CMD_CHECK: begin
        if (state.running) begin
          if (cfg.check_tilt) begin
            if (tilt) begin
              if (state.tilt_count != 3'd7) state_next.tilt_count = state.tilt_count + 3'd1;
            end else begin
              state_next.tilt_count = '0;
            end
            if (item.supply_mv < rps_pkg::LOW_VOLT_MV) begin
              if (state.low_volt_count != 5'd31) begin
                state_next.low_volt_count = state.low_volt_count + 5'd1;
              end
            end else begin
              state_next.low_volt_count = '0;
            end
            if (state_next.tilt_count >= rps_pkg::TILT_LIMIT) begin
              state_next.running = 1'b0;
              reason             = rps_pkg::REASON_TILT;
              stopped            = 1'b1;
            end else if (state_next.low_volt_count >= rps_pkg::LOW_VOLT_LIMIT) begin
              state_next.running = 1'b0;
              reason             = rps_pkg::REASON_LOW_VOLT;
              stopped            = 1'b1;
            end
          end
          if (!stopped && !cfg.constant_mode) begin
            if (diff > -rps_pkg::WINDOW_TENTHS && diff < rps_pkg::WINDOW_TENTHS) begin
              state_next.dwell_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            if (state_next.dwell_ms >=
                {6'b0, rps_pkg::sec_to_ms(cfg.stage_dur[state.stage])}) begin
              if (has_next) begin
                state_next.stage    = next_idx;
                state_next.dwell_ms = '0;
              end else begin
                state_next.running = 1'b0;
                reason             = rps_pkg::REASON_DONE;
              end
            end
          end
        end
      end
      default: ;
    endcase

    result.heater_on   = state_next.running;
    result.target_temp = cfg.constant_mode ? cfg.stage_temp[0]
                                           : cfg.stage_temp[state_next.stage];
    result.max_power   = cfg.watt_limit;
    result.stage_now   = 3'(state_next.stage);
    result.stop_reason = reason;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Any stop reported leaves the heater off.
  assert property (@(posedge clk) disable iff (rst)
    advance && result.stop_reason != rps_pkg::REASON_NONE |=> !state.running)
    else $error("stop reported but sequencer still running");

  // A start re-arms from the first stage with cleared counters.
  assert property (@(posedge clk) disable iff (rst)
    advance && item.cmd == rps_pkg::CMD_START |=>
      state.running && state.stage == '0 && state.dwell_ms == '0 &&
      state.tilt_count == '0 && state.low_volt_count == '0)
    else $error("start did not re-arm the sequencer");

  // State only moves when a transaction is processed.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("sequencer state changed without a transaction");

  // A check moves at most one stage forward.
  assert property (@(posedge clk) disable iff (rst)
    advance && item.cmd == rps_pkg::CMD_CHECK |=>
      state.stage == $past(state.stage) ||
      {1'b0, state.stage} == {1'b0, $past(state.stage)} + 1'b1)
    else $error("stage skipped during a check");

endmodule

`default_nettype wire
